/* design/lmd_pkg.sv */
// Shared types, constants and the quarter-wave cosine table of the LFO delay line.
// No dependencies; every other design file apart from lmd_ram imports this package.
`timescale 1ns / 1ps

package lmd_pkg;

  // Sizes
  localparam int SAMPLE_BITS     = 16;
  localparam int DELAY_WORDS     = 1024;
  localparam int COS_TABLE_WORDS = 1024;
  localparam int PHASE_BITS      = 32;
  localparam int DEPTH_BITS      = 18;
  localparam int DEPTH_FRAC      = 8;
  localparam int QUEUE_WORDS     = 2;

  localparam int ADDR_BITS    = $clog2(DELAY_WORDS);
  localparam int COS_IDX_BITS = $clog2(COS_TABLE_WORDS);
  localparam int QTR_BITS     = COS_IDX_BITS - 2;
  localparam int QTR_WORDS    = COS_TABLE_WORDS / 4;
  localparam int Y_SHIFT      = 16 - QTR_BITS;

  // Weight is unsigned Q16 in [0, 1.0]
  localparam int WEIGHT_FRAC = 16;
  localparam int WEIGHT_BITS = WEIGHT_FRAC + 1;
  localparam int W_SHIFT     = 15;

  // Mix gains, Q15
  localparam logic signed [15:0] WET_GAIN = 16'sd29491;
  localparam logic signed [15:0] DRY_GAIN = 16'sd3277;

  // Cosine polynomial, Q30
  localparam longint COEF1 = 64'sd1324675830;
  localparam longint COEF2 = 64'sd272375564;
  localparam longint COEF3 = 64'sd22401990;
  localparam longint COEF4 = 64'sd987050;
  localparam longint Q30_ONE = 64'sd1073741824;

  // Register indexes (paddr[3:2])
  localparam int PADDR_BITS = 4;
  localparam logic [1:0] REG_ENABLE      = 2'd0;
  localparam logic [1:0] REG_PHASE_STEP  = 2'd1;
  localparam logic [1:0] REG_DELAY_DEPTH = 2'd2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [WEIGHT_BITS-1:0]        weight_t;

  // One queued beat: current sample, marker and its LFO weight
  typedef struct packed {
    sample_t sample;
    logic    block_end;
    weight_t weight;
  } item_t;

  typedef logic signed [31:0] cos_word_t;
  typedef cos_word_t cos_tbl_t [QTR_WORDS];

  function automatic longint qcos_eval(input longint y);
    longint z;
    longint p;
    z = (y * y) / 65536;
    p = COEF4;
    p = COEF3 - (p * z) / 65536;
    p = COEF2 - (p * z) / 65536;
    p = COEF1 - (p * z) / 65536;
    p = Q30_ONE - (p * z) / 65536;
    return p;
  endfunction

  function automatic cos_tbl_t build_cos_tbl();
    cos_tbl_t t;
    for (int i = 0; i < QTR_WORDS; i++) begin
      t[i] = 32'(qcos_eval(longint'(i) << Y_SHIFT));
    end
    return t;
  endfunction

  localparam cos_tbl_t  COS_TBL = build_cos_tbl();
  // Quarter turn exactly: y = 1.0
  localparam cos_word_t COS_END = 32'(qcos_eval(longint'(QTR_WORDS) << Y_SHIFT));

endpackage

/* design/lmd_in_if.sv */
// Input sample channel: valid/ready handshake with sample and block marker.
// Depends on lmd_pkg.
`timescale 1ns / 1ps

interface lmd_in_if;
  import lmd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_in;
  logic    block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

/* design/lmd_out_if.sv */
// Result sample channel: valid/ready handshake with mixed sample and block marker.
// Depends on lmd_pkg.
`timescale 1ns / 1ps

interface lmd_out_if;
  import lmd_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    block_end_out;

  modport source (output valid, output sample_out, output block_end_out, input ready);
  modport sink   (input valid, input sample_out, input block_end_out, output ready);
endinterface

/* design/lfo_modulated_delay_line_unit.sv */
// LFO modulated delay line: vibrato delay with linear interpolation and dry mix.
// The back sequencer takes one beat at a time through its states (one write and two
// reads on the single delay RAM port pair, then the multiply chain); the front can
// accept further input beats meanwhile until the queue is full.
// Reset: synchronous active-low; registers, phase and write position go to zero,
// and a fill count makes never-written store entries read as zero (no clear pass).
// Depends on lmd_pkg, lmd_in_if, lmd_out_if, lmd_front, lmd_queue, lmd_back.
`timescale 1ns / 1ps

module lfo_modulated_delay_line_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lmd_in_if.sink                        in_ch,
  lmd_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lmd_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lmd_pkg::*;

  // Configuration registers
  logic                  enable_r;
  logic [PHASE_BITS-1:0] phase_step_r;
  logic [DEPTH_BITS-1:0] depth_r;

  logic                  cfg_wr;
  logic                  depth_wr;
  logic [1:0]            reg_idx;

  // Front/back queue signals
  logic                  q_push;
  item_t                 q_push_item;
  logic                  q_full;
  logic                  q_pop;
  item_t                 q_head;
  logic                  q_empty;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_BITS-1:2];
  // Write lands in the access phase of the APB transfer
  assign cfg_wr  = psel && penable && pwrite;

  // A depth write also empties the store: write position and fill count restart
  assign depth_wr = cfg_wr && (reg_idx == REG_DELAY_DEPTH);

  always_comb begin
    unique case (reg_idx)
      REG_ENABLE:      prdata = {31'b0, enable_r};
      REG_PHASE_STEP:  prdata = 32'(phase_step_r);
      REG_DELAY_DEPTH: prdata = 32'(depth_r);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      phase_step_r <= '0;
      depth_r      <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ENABLE:      enable_r     <= pwdata[0];
        REG_PHASE_STEP:  phase_step_r <= PHASE_BITS'(pwdata);
        REG_DELAY_DEPTH: depth_r      <= pwdata[DEPTH_BITS-1:0];
        default: ;  // unmapped address: ignored
      endcase
    end
  end

  // Front: accept, drop while disabled, phase step and cosine weight
  lmd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (enable_r),
    .phase_step(phase_step_r),
    .in_ch     (in_ch),
    .push      (q_push),
    .push_item (q_push_item),
    .q_full    (q_full)
  );

  // Decouples the weight path from the memory/multiply sequencer
  lmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_item(q_push_item),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back: store write, tap reads, interpolation, mix, saturation, output register
  lmd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .delay_depth(depth_r),
    .depth_wr   (depth_wr),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );
endmodule

/* design/lmd_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module lmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* design/lmd_queue.sv */
// Short register queue of beats between the front and back sections.
// Depends on lmd_pkg.
`timescale 1ns / 1ps

module lmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lmd_pkg::item_t push_item,
  output logic          full,
  input  logic          pop,
  output lmd_pkg::item_t head,
  output logic          empty
);
  import lmd_pkg::*;

  localparam int PTR_BITS = (QUEUE_WORDS > 1) ? $clog2(QUEUE_WORDS) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_WORDS + 1);

  item_t                slot_r [QUEUE_WORDS];
  logic [PTR_BITS-1:0]  wr_ptr_r;
  logic [PTR_BITS-1:0]  rd_ptr_r;
  logic [CNT_BITS-1:0]  count_r;
  logic                 do_push;
  logic                 do_pop;

  assign full    = (count_r == CNT_BITS'(QUEUE_WORDS));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  function automatic logic [PTR_BITS-1:0] ptr_inc(input logic [PTR_BITS-1:0] p);
    return (p == PTR_BITS'(QUEUE_WORDS - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_ptr_r] <= push_item;
        wr_ptr_r         <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end
endmodule

/* design/lmd_front.sv */
// Front section: takes input beats, drops them while disabled, advances the LFO
// phase and derives the cosine weight, then queues the beat. Depends on lmd_pkg.
`timescale 1ns / 1ps

module lmd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          enable,
  input  logic [lmd_pkg::PHASE_BITS-1:0] phase_step,
  lmd_in_if.sink                        in_ch,
  output logic                          push,
  output lmd_pkg::item_t                push_item,
  input  logic                          q_full
);
  import lmd_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_LOOK, F_WGT, F_PUSH} fstate_t;

  fstate_t                 state_r;
  logic [PHASE_BITS-1:0]   phase_r;
  sample_t                 x_r;
  logic                    be_r;
  weight_t                 w_r;
  logic [QTR_BITS-1:0]     tidx_r;
  logic                    at_end_r;
  logic                    neg_r;

  logic [COS_IDX_BITS-1:0] k;
  logic [1:0]              quad;
  logic [QTR_BITS:0]       m;
  cos_word_t               c;
  logic signed [33:0]      cs;
  logic signed [33:0]      s;
  logic [31:0]             s_clamp;
  logic                    accept;

  assign in_ch.ready = (state_r == F_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = (state_r == F_PUSH) && !q_full;
  assign push_item   = '{sample: x_r, block_end: be_r, weight: w_r};

  // Table index: mirror the angle in odd quadrants, negate in quadrants 1 and 2
  always_comb begin
    k    = phase_r[PHASE_BITS-1 -: COS_IDX_BITS];
    quad = k[COS_IDX_BITS-1 -: 2];
    if (quad[0]) begin
      m = (QTR_BITS+1)'(QTR_WORDS) - {1'b0, k[QTR_BITS-1:0]};
    end else begin
      m = {1'b0, k[QTR_BITS-1:0]};
    end
  end

  // w = clamp(1 + cos, 0, 2) in Q30, then halved to Q16 (weight in [0, 1.0])
  always_comb begin
    c  = at_end_r ? COS_END : COS_TBL[tidx_r];
    cs = neg_r ? -34'(c) : 34'(c);
    s  = 34'(Q30_ONE) + cs;
    if (s < 0) begin
      s_clamp = '0;
    end else if (s > 34'(2 * Q30_ONE)) begin
      s_clamp = 32'(2 * Q30_ONE);
    end else begin
      s_clamp = s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      phase_r <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept && enable) begin
            x_r     <= in_ch.sample_in;
            be_r    <= in_ch.block_end;
            phase_r <= phase_r + phase_step;
            state_r <= F_LOOK;
          end
        end
        F_LOOK: begin
          tidx_r   <= m[QTR_BITS-1:0];
          at_end_r <= m[QTR_BITS];
          neg_r    <= quad[1] ^ quad[0];
          state_r  <= F_WGT;
        end
        F_WGT: begin
          w_r     <= s_clamp[W_SHIFT + WEIGHT_BITS - 1:W_SHIFT];
          state_r <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end
endmodule

/* design/lmd_back.sv */
// Back section: writes the sample into the delay store, reads the two taps,
// interpolates, mixes and saturates. Depends on lmd_pkg, lmd_ram, lmd_out_if.
`timescale 1ns / 1ps

module lmd_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [lmd_pkg::DEPTH_BITS-1:0] delay_depth,
  input  logic                          depth_wr,
  input  lmd_pkg::item_t                head,
  input  logic                          q_empty,
  output logic                          pop,
  lmd_out_if.source                     out_ch
);
  import lmd_pkg::*;

  localparam int LEN_BITS  = ADDR_BITS + 1;
  localparam int DINT_BITS = DEPTH_BITS - DEPTH_FRAC;
  localparam int LRAW_BITS = DINT_BITS + 1;
  localparam int DISP_BITS = WEIGHT_BITS + DEPTH_BITS;
  localparam int INT_LSB   = WEIGHT_FRAC + DEPTH_FRAC;
  localparam int INT_BITS  = DISP_BITS - INT_LSB;
  localparam int SUM_BITS  = ((INT_BITS > LEN_BITS) ? INT_BITS : LEN_BITS) + 1;
  localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_FRAC + 2;
  localparam int WET_BITS  = PROD_BITS + 1;
  localparam int MIX_BITS  = WET_BITS + 16;
  localparam int DRY_BITS  = SAMPLE_BITS + 16;
  localparam int TOT_BITS  = MIX_BITS + 1;
  localparam int OUT_SHIFT = 31;
  localparam int QW        = TOT_BITS - OUT_SHIFT;
  localparam longint ROUND_HALF = 64'sd1 <<< (OUT_SHIFT - 1);
  localparam logic signed [QW-1:0] Q_HI = QW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] Q_LO = -Q_HI - QW'(1);

  typedef enum logic [3:0] {
    B_IDLE, B_WRITE, B_ADDR, B_RDA, B_RDB, B_LATB, B_MULT, B_SUM, B_MIX, B_OUT
  } bstate_t;

  bstate_t                     state_r;
  logic [ADDR_BITS-1:0]        wp_r;
  logic [LEN_BITS-1:0]         fill_r;
  sample_t                     x_r;
  logic                        be_r;
  weight_t                     w_r;
  logic [DISP_BITS-1:0]        disp_r;
  logic signed [DRY_BITS-1:0]  dry_r;
  logic [ADDR_BITS-1:0]        ai_r;
  logic [ADDR_BITS-1:0]        bi_r;
  sample_t                     sa_r;
  sample_t                     sb_r;
  logic signed [PROD_BITS-1:0] pa_r;
  logic signed [PROD_BITS-1:0] pb_r;
  logic signed [WET_BITS-1:0]  wet_r;
  logic signed [MIX_BITS-1:0]  mix_r;
  logic                        out_valid_r;
  sample_t                     sample_out_r;
  logic                        be_out_r;

  logic [LRAW_BITS-1:0]        len_raw;
  logic [LEN_BITS-1:0]         len;
  logic [LEN_BITS-1:0]         wp_inc;
  logic [ADDR_BITS-1:0]        wp_nxt;
  logic [LEN_BITS-1:0]         fill_nxt;
  logic [WEIGHT_FRAC-1:0]      frac;
  logic [SUM_BITS-1:0]         sum_a;
  logic [SUM_BITS-1:0]         sum_b;
  logic [SUM_BITS-1:0]         len_x;
  logic [SUM_BITS-1:0]         ai_full;
  logic [SUM_BITS-1:0]         bi_full;
  logic signed [17:0]          wa;
  logic signed [17:0]          wb;
  logic signed [TOT_BITS-1:0]  total;
  logic signed [QW-1:0]        quot;
  sample_t                     sat;
  logic                        ram_we;
  logic [ADDR_BITS-1:0]        ram_raddr;
  sample_t                     ram_rdata;
  sample_t                     rd_val;
  logic [ADDR_BITS-1:0]        rd_addr;
  logic                        out_load;

  // Active length floor(depth)+1, capped at the store size
  always_comb begin
    len_raw = {1'b0, delay_depth[DEPTH_BITS-1:DEPTH_FRAC]} + LRAW_BITS'(1);
    if (32'(len_raw) > 32'(DELAY_WORDS)) begin
      len = LEN_BITS'(DELAY_WORDS);
    end else begin
      len = LEN_BITS'(len_raw);
    end
    wp_inc   = {1'b0, wp_r} + LEN_BITS'(1);
    wp_nxt   = (wp_inc == len) ? '0 : wp_inc[ADDR_BITS-1:0];
    fill_nxt = (fill_r == len) ? fill_r : fill_r + 1'b1;
  end

  // Tap addresses: both sums stay below twice the length, one subtract wraps
  always_comb begin
    frac    = disp_r[INT_LSB-1:DEPTH_FRAC];
    len_x   = SUM_BITS'(len);
    sum_a   = SUM_BITS'(wp_r) + SUM_BITS'(disp_r[DISP_BITS-1:INT_LSB]);
    sum_b   = sum_a + SUM_BITS'(1);
    ai_full = (sum_a >= len_x) ? sum_a - len_x : sum_a;
    bi_full = (sum_b >= len_x) ? sum_b - len_x : sum_b;
    wa      = $signed({1'b0, 17'(17'(1 << WEIGHT_FRAC) - {1'b0, frac})});
    wb      = $signed({2'b0, frac});
  end

  // Entries at or past the fill count count as cleared and read as zero
  assign rd_addr = (state_r == B_RDB) ? ai_r : bi_r;
  assign rd_val  = ({1'b0, rd_addr} < fill_r) ? ram_rdata : '0;

  // Round to nearest (floor of t + half), then saturate
  always_comb begin
    total = TOT_BITS'(mix_r) + (TOT_BITS'(dry_r) <<< 16) + TOT_BITS'(ROUND_HALF);
    quot  = total[TOT_BITS-1:OUT_SHIFT];
    if (quot > Q_HI) begin
      sat = Q_HI[SAMPLE_BITS-1:0];
    end else if (quot < Q_LO) begin
      sat = Q_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = quot[SAMPLE_BITS-1:0];
    end
  end

  assign pop       = (state_r == B_IDLE) && !q_empty;
  assign ram_we    = (state_r == B_WRITE);
  assign ram_raddr = (state_r == B_RDA) ? ai_r : bi_r;
  // Output register takes a new beat when empty or being drained this cycle
  assign out_load  = (state_r == B_OUT) && (!out_valid_r || out_ch.ready);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_out    = sample_out_r;
  assign out_ch.block_end_out = be_out_r;

  lmd_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DELAY_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wp_r),
    .wdata(x_r),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (depth_wr) begin
        wp_r   <= '0;
        fill_r <= '0;
      end else if (state_r == B_WRITE) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            x_r     <= head.sample;
            be_r    <= head.block_end;
            w_r     <= head.weight;
            state_r <= B_WRITE;
          end
        end
        B_WRITE: begin
          disp_r  <= DISP_BITS'(w_r) * DISP_BITS'(delay_depth);
          dry_r   <= DRY_BITS'(x_r) * DRY_BITS'(DRY_GAIN);
          state_r <= B_ADDR;
        end
        B_ADDR: begin
          ai_r    <= ai_full[ADDR_BITS-1:0];
          bi_r    <= bi_full[ADDR_BITS-1:0];
          state_r <= B_RDA;
        end
        B_RDA: state_r <= B_RDB;
        B_RDB: begin
          sa_r    <= rd_val;
          state_r <= B_LATB;
        end
        B_LATB: begin
          sb_r    <= rd_val;
          state_r <= B_MULT;
        end
        B_MULT: begin
          pa_r    <= PROD_BITS'(sa_r) * PROD_BITS'(wa);
          pb_r    <= PROD_BITS'(sb_r) * PROD_BITS'(wb);
          state_r <= B_SUM;
        end
        B_SUM: begin
          wet_r   <= WET_BITS'(pa_r) + WET_BITS'(pb_r);
          state_r <= B_MIX;
        end
        B_MIX: begin
          mix_r   <= MIX_BITS'(wet_r) * MIX_BITS'(WET_GAIN);
          state_r <= B_OUT;
        end
        B_OUT: begin
          if (out_load) begin
            sample_out_r <= sat;
            be_out_r     <= be_r;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end
endmodule

/* dv/tb_lfo_modulated_delay_line_unit.sv */
// Self-checking testbench for the LFO modulated delay line unit: a bit-exact predictor
// of the interpolated delay tap and dry mix, APB register writes, random idling on both sides.
// Depends on lmd_pkg, lmd_in_if, lmd_out_if and the lfo_modulated_delay_line_unit RTL.
`timescale 1ns / 1ps

module tb_lfo_modulated_delay_line_unit;
  import lmd_pkg::*;

  // Run control
  localparam int WATCHDOG_LIMIT = 5000;  // quiet cycles before giving up (longer than the hold-off)
  localparam int SETTLE_CYCLES  = 64;    // extra wait after the last owed result, for the pipeline to drain
  localparam int HOLD_CYCLES    = 300;   // long result-side hold-off
  localparam int MAX_REPORTS    = 10;
  localparam int RANDOM_BEATS   = 400;

  // Register index with no register behind it
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Quarter-wave cosine polynomial, Q30, and Q15 mix gains (0.9 wet, 0.1 dry)
  localparam longint POLY_C1 = 64'sd1324675830;
  localparam longint POLY_C2 = 64'sd272375564;
  localparam longint POLY_C3 = 64'sd22401990;
  localparam longint POLY_C4 = 64'sd987050;
  localparam longint MIX_WET = 64'sd29491;
  localparam longint MIX_DRY = 64'sd3277;
  localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

  typedef struct {
    sample_t sample;
    logic    block_end;
  } mix_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  lmd_in_if  in_ch ();
  lmd_out_if out_ch ();

  lfo_modulated_delay_line_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: its own copy of the delay store, write pointer, LFO phase
  // and registers. Updated at every input beat taken while enabled and every mapped register write.
  // ---------------------------------------------------------------------------
  sample_t                delay_copy [DELAY_WORDS];
  int unsigned            wr_pos;
  logic [PHASE_BITS-1:0]  lfo_acc;
  logic                   cfg_enable;
  logic [31:0]            cfg_step;
  logic [DEPTH_BITS-1:0]  cfg_depth;

  // Mixed samples still owed by the block, oldest first
  mix_beat_t expected_mix [$];

  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int hold_trigger    = 0;
  int beats_in        = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int mismatches      = 0;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input longint want_v, input longint got_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, want_v, got_v);
    end
  endtask

  function automatic void clear_delay_copy();
    foreach (delay_copy[i]) delay_copy[i] = '0;
    wr_pos = 0;
  endfunction

  // cos of a quarter-turn fraction y (Q16, 0..65536), Q30, Horner with truncating steps
  function automatic longint quarter_wave(input longint y);
    longint z;
    longint p;
    z = (y * y) / 65536;
    p = POLY_C4;
    p = POLY_C3 - (p * z) / 65536;
    p = POLY_C2 - (p * z) / 65536;
    p = POLY_C1 - (p * z) / 65536;
    p = (64'sd1 <<< 30) - (p * z) / 65536;
    return p;
  endfunction

  // LFO weight (cos+1)/2 as unsigned Q16 for table index k
  function automatic longint lfo_weight(input logic [COS_IDX_BITS-1:0] k);
    longint pos;
    longint x;
    longint y;
    longint c;
    int     quad;
    pos  = longint'(k) * 4 * 65536 / COS_TABLE_WORDS;
    quad = int'((pos >>> 16) & 3);
    x    = pos & 64'hFFFF;
    y    = (quad % 2 == 1) ? 65536 - x : x;
    c    = quarter_wave(y);
    if (quad == 1 || quad == 2) c = -c;
    c = c + (64'sd1 <<< 30);
    if (c < 0) c = 0;
    if (c > (64'sd1 <<< 31)) c = 64'sd1 <<< 31;
    return c / 32768;
  endfunction

  // One accepted input beat: write the store, step the LFO, read the two taps,
  // interpolate, mix with the dry sample, round and saturate.
  function automatic void predict_mix(input sample_t smp, input logic last);
    longint    len;
    longint    w;
    longint    disp;
    longint    a;
    longint    f;
    longint    ai;
    longint    bi;
    longint    wet;
    longint    total;
    longint    q;
    mix_beat_t beat;
    if (!cfg_enable) return;  // disabled: beat is dropped, state untouched
    len = longint'(cfg_depth >> DEPTH_FRAC) + 1;
    if (len > DELAY_WORDS) len = DELAY_WORDS;  // depth past the store saturates
    if (wr_pos >= len) wr_pos = 0;             // stray write position
    delay_copy[wr_pos] = smp;
    wr_pos  = int'((longint'(wr_pos) + 1) % len);
    lfo_acc = lfo_acc + cfg_step;
    w       = lfo_weight(lfo_acc[PHASE_BITS-1 -: COS_IDX_BITS]);
    disp    = w * longint'(cfg_depth);         // Q.24 displacement
    a       = disp >>> 24;
    f       = (disp >>> 8) & 64'hFFFF;
    ai      = (longint'(wr_pos) + a) % len;
    bi      = (longint'(wr_pos) + a + 1) % len;
    wet     = longint'(delay_copy[ai]) * (65536 - f) + longint'(delay_copy[bi]) * f;
    total   = wet * MIX_WET + longint'(smp) * 65536 * MIX_DRY;
    q       = (total + (64'sd1 <<< 30)) >>> 31;
    if (q > SAMPLE_MAX) q = SAMPLE_MAX;
    if (q < SAMPLE_MIN) q = SAMPLE_MIN;
    beat.sample    = sample_t'(q);
    beat.block_end = last;
    expected_mix.push_back(beat);
  endfunction

  function automatic logic [31:0] reg_value(input logic [1:0] idx);
    case (idx)
      REG_ENABLE:      return {31'b0, cfg_enable};
      REG_PHASE_STEP:  return cfg_step;
      REG_DELAY_DEPTH: return {{(32 - DEPTH_BITS){1'b0}}, cfg_depth};
      default:         return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: ready toggles at random with the current idle share; a request
  // from a test starts a long hold-off counted here.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_trigger != hold_seen) begin
        hold_seen = hold_trigger;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Every result beat against the oldest expected one
  always @(posedge clk) begin
    mix_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_mix.size() == 0) begin
        report_mismatch("result beat with nothing expected", 0, out_ch.sample_out);
      end else begin
        want = expected_mix.pop_front();
        results_checked++;
        if (out_ch.sample_out !== want.sample)
          report_mismatch("sample_out", want.sample, out_ch.sample_out);
        if (out_ch.block_end_out !== want.block_end)
          report_mismatch("block_end_out", want.block_end, out_ch.block_end_out);
      end
    end
  end

  // Watchdog: any beat or register access restarts the count
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: nothing moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb_lfo_modulated_delay_line_unit failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------

  // Offer one input beat after a random idle spell; predict once it is taken.
  // valid stays high on return so back-to-back beats never drop it.
  task automatic push_beat(input sample_t smp, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= smp;
    in_ch.block_end <= last;
    do @(posedge clk); while (!in_ch.ready);
    beats_in++;
    predict_mix(smp, last);
  endtask

  // Stop offering, wait for every owed result, then let the pipeline drain
  // (dropped beats while disabled leave nothing to wait on).
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB setup + access phase, then back to idle
  task automatic apb_access(input logic [1:0] idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx);
    logic [31:0] rd;
    apb_access(idx, 1'b0, '0, rd);
    if (rd !== reg_value(idx))
      report_mismatch($sformatf("register %0d readback", idx), reg_value(idx), rd);
  endtask

  // Register write, only with the block idle; a depth write clears the store
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    settle_block();
    apb_access(idx, 1'b1, value, rd);
    reg_writes++;
    case (idx)
      REG_ENABLE:      cfg_enable = value[0];
      REG_PHASE_STEP:  cfg_step = value;
      REG_DELAY_DEPTH: begin
        cfg_depth = value[DEPTH_BITS-1:0];
        clear_delay_copy();  // LFO phase is kept
      end
      default: ;             // unmapped index: no effect
    endcase
    if (idx != REG_SPARE) check_reg(idx);
  endtask

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h8000);
      1:       return sample_t'(16'h7FFF);
      2:       return sample_t'($urandom_range(0, 63)) - sample_t'(32);
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  // New depth and LFO step, sometimes with a short disabled stretch
  task automatic shuffle_settings();
    logic [31:0] depth;
    logic [31:0] step;
    case ($urandom_range(0, 4))
      0:       depth = $urandom_range(0, 255);         // single-word line
      1:       depth = $urandom_range(256, 4095);
      2:       depth = $urandom_range(0, 262143);
      3:       depth = 32'h3FFFF;                      // store length at its maximum
      default: depth = $urandom_range(1, 8) * 256;     // whole samples
    endcase
    case ($urandom_range(0, 4))
      0:       step = '0;
      1:       step = $urandom_range(0, 32'h0100_0000);  // slow LFO
      2:       step = $urandom;
      3:       step = 32'hFFFF_FFFF;
      default: step = $urandom_range(1, 64) << 22;      // whole table steps
    endcase
    write_reg(REG_DELAY_DEPTH, depth);
    write_reg(REG_PHASE_STEP, step);
    if ($urandom_range(0, 3) == 0) begin
      write_reg(REG_ENABLE, 32'd0);
      repeat (2) push_beat(pick_sample(), 1'($urandom_range(0, 1)));
      write_reg(REG_ENABLE, 32'd1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values read back as zero; a write to the unmapped index changes nothing
  task automatic test_register_access();
    check_reg(REG_ENABLE);
    check_reg(REG_PHASE_STEP);
    check_reg(REG_DELAY_DEPTH);
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    check_reg(REG_ENABLE);
    check_reg(REG_PHASE_STEP);
    check_reg(REG_DELAY_DEPTH);
  endtask

  // Disabled after reset: beats are taken, no result and no state change
  task automatic test_disabled_input();
    push_beat(sample_t'(16'h7FFF), 1'b0);
    push_beat(sample_t'(16'h8000), 1'b1);
    push_beat(sample_t'(16'h1234), 1'b0);
    settle_block();
  endtask

  // Zero depth, zero step: output is mostly the current sample; full-scale values
  task automatic test_sample_extremes();
    write_reg(REG_ENABLE, 32'd1);
    write_reg(REG_DELAY_DEPTH, 32'd0);
    write_reg(REG_PHASE_STEP, 32'd0);
    push_beat(sample_t'(16'h8000), 1'b0);
    push_beat(sample_t'(16'h7FFF), 1'b1);
    push_beat(sample_t'(16'h0000), 1'b0);
    push_beat(sample_t'(16'hFFFF), 1'b1);
    push_beat(sample_t'(16'h0001), 1'b0);
    push_beat(sample_t'(16'h5555), 1'b0);
    push_beat(sample_t'(16'hAAAA), 1'b1);
    push_beat(sample_t'(16'h7FFF), 1'b1);
  endtask

  // Maximum depth and step, then a two-word line where taps wrap every beat
  task automatic test_depth_wrap();
    write_reg(REG_DELAY_DEPTH, 32'h3FFFF);
    write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
    repeat (5) push_beat(pick_sample(), 1'b0);
    write_reg(REG_DELAY_DEPTH, 32'h1FF);
    write_reg(REG_PHASE_STEP, 32'h0040_0000);
    push_beat(sample_t'(16'h7FFF), 1'b0);
    push_beat(sample_t'(16'h8000), 1'b0);
    push_beat(sample_t'(16'h7FFF), 1'b0);
    push_beat(sample_t'(16'h8000), 1'b0);
    push_beat(sample_t'(16'h4000), 1'b1);
  endtask

  // Blocks of random samples closed by block_end, with stray markers as noise
  task automatic run_random_phase(input int send_pct, input int recv_pct, input int beats);
    int sent;
    int chunk;
    int left_in_block;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < beats) begin
      shuffle_settings();
      chunk = $urandom_range(30, 50);
      left_in_block = $urandom_range(1, 24);
      repeat (chunk) begin
        left_in_block--;
        push_beat(pick_sample(), (left_in_block == 0) || ($urandom_range(0, 19) == 0));
        if (left_in_block == 0) left_in_block = $urandom_range(1, 24);
      end
      sent += chunk;
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(38, 82, RANDOM_BEATS / 3);
    run_random_phase(82, 38, RANDOM_BEATS / 3);
    run_random_phase(0, 0, RANDOM_BEATS - 2 * (RANDOM_BEATS / 3));
  endtask

  // Result side held off while beats keep coming: the block fills and stalls
  // its input; afterwards the sender waits for every result.
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_trigger <= hold_trigger + 1;
    repeat (20) push_beat(pick_sample(), 1'($urandom_range(0, 1)));
    settle_block();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.sample_in <= '0;
    in_ch.block_end <= 1'b0;
    cfg_enable = 1'b0;
    cfg_step   = '0;
    cfg_depth  = '0;
    lfo_acc    = '0;
    clear_delay_copy();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_disabled_input();
    test_sample_extremes();
    test_depth_wrap();
    test_random_traffic();
    test_output_hold();
    settle_block();

    $display("Run: %0d input beats, %0d results checked, %0d register writes, %0d mismatches",
             beats_in, results_checked, reg_writes, mismatches);
    $display("Covered reset readback, disabled input, extremes, depth/step sweeps, %0d-cycle hold",
             HOLD_CYCLES);
    if (mismatches == 0 && expected_mix.size() == 0) begin
      $display("tb_lfo_modulated_delay_line_unit passed");
    end else begin
      $display("tb_lfo_modulated_delay_line_unit failed");
    end
    $finish;
  end

endmodule
